@@ hdl/qsa_pkg.sv @@
// qsa_pkg: shared constants, types and codes of the query slot allocator.
// No dependencies; every other file except qsa_ram imports it.
package qsa_pkg;

  localparam int SLOTS   = 64;
  localparam int HandleW = $clog2(SLOTS);
  localparam int ResW    = 6;
  localparam int PoolW   = 7;
  localparam int CntW    = HandleW + 1;
  localparam int NumRes  = 64;

  localparam logic [PoolW-1:0] PoolSizeReset = PoolW'(NumRes);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take the item, launch the memory reads
    logic commit;    // read data is back: update state, load result
    logic in_ready;
    logic out_valid;
  } cmd_t;

endpackage

@@ hdl/qsa_if.sv @@
// qsa_req_if / qsa_rsp_if: valid/ready channels for requests and results.
// Depends on qsa_pkg.
interface qsa_req_if import qsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [HandleW-1:0] handle;

  modport source (output valid, kind, handle, input ready);
  modport sink   (input valid, kind, handle, output ready);
endinterface

interface qsa_rsp_if import qsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [HandleW-1:0] granted_handle;
  logic [ResW-1:0]    resource_number;

  modport source (output valid, status, granted_handle, resource_number, input ready);
  modport sink   (input valid, status, granted_handle, resource_number, output ready);
endinterface

@@ hdl/qsa_ram.sv @@
// qsa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module qsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/qsa_ctrl.sv @@
// qsa_ctrl: sequencing state machine (capture, commit, present result).
// Depends on qsa_pkg.
module qsa_ctrl import qsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_valid = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.in_ready && cmd_o.out_valid))
    else $error("accept and result offered together");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_OUT)
    else $error("commit not followed by result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && !out_ready_i |=> state_q == S_OUT)
    else $error("result dropped while stalled");

endmodule

@@ hdl/qsa_datapath.sv @@
// qsa_datapath: resource bitmap, handle bitmap, handle->resource map,
// freed-handle stack and result registers. Depends on qsa_pkg, qsa_ram.
module qsa_datapath import qsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               kind_i,
  input  logic [HandleW-1:0] handle_i,
  input  logic               cfg_we_i,
  input  logic [PoolW-1:0]   cfg_wdata_i,
  output status_e            status_o,
  output logic [HandleW-1:0] granted_handle_o,
  output logic [ResW-1:0]    resource_number_o
);

  logic [PoolW-1:0]   pool_size_q;
  logic [NumRes-1:0]  taken_q, taken_d;
  logic [SLOTS-1:0]   in_use_q, in_use_d;
  logic [CntW-1:0]    depth_q, depth_d;
  logic [CntW-1:0]    issued_q, issued_d;
  logic               kind_q;
  logic [HandleW-1:0] handle_q;
  status_e            status_q, status_d;
  logic [HandleW-1:0] gh_q, gh_d;
  logic [ResW-1:0]    rn_q, rn_d;

  logic [PoolW-1:0]   eff_size;
  logic [NumRes-1:0]  free_vec;
  logic               found;
  logic [ResW-1:0]    pick;
  logic [CntW-1:0]    depth_m1;
  logic [HandleW-1:0] stack_rdata;
  logic [ResW-1:0]    hres_rdata;
  logic               stack_we, hres_we;
  logic [HandleW-1:0] new_handle;
  logic               acq_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= PoolSizeReset;
    end else if (cfg_we_i) begin
      pool_size_q <= cfg_wdata_i;
    end
  end

  // Lowest free resource below the effective pool size.
  assign eff_size = (pool_size_q > PoolW'(NumRes)) ? PoolW'(NumRes) : pool_size_q;

  always_comb begin
    for (int i = 0; i < NumRes; i++) begin
      free_vec[i] = !taken_q[i] && (PoolW'(i) < eff_size);
    end
  end

  assign found = |free_vec;

  always_comb begin
    pick = '0;
    for (int i = NumRes - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pick = ResW'(i);
      end
    end
  end

  assign depth_m1   = depth_q - CntW'(1);
  assign new_handle = (depth_q != '0) ? stack_rdata : issued_q[HandleW-1:0];
  assign acq_ok     = found && !(depth_q == '0 && issued_q >= CntW'(SLOTS));

  qsa_ram #(.Width(HandleW), .Depth(SLOTS)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (depth_q[HandleW-1:0]),
    .wdata_i (handle_q),
    .raddr_i (depth_m1[HandleW-1:0]),
    .rdata_o (stack_rdata)
  );

  qsa_ram #(.Width(ResW), .Depth(SLOTS)) u_hres (
    .clk_i   (clk_i),
    .we_i    (hres_we),
    .waddr_i (new_handle),
    .wdata_i (pick),
    .raddr_i (handle_i),
    .rdata_o (hres_rdata)
  );

  always_comb begin
    taken_d  = taken_q;
    in_use_d = in_use_q;
    depth_d  = depth_q;
    issued_d = issued_q;
    status_d = status_q;
    gh_d     = gh_q;
    rn_d     = rn_q;
    stack_we = 1'b0;
    hres_we  = 1'b0;
    if (cmd_i.commit) begin
      status_d = ST_OK;
      gh_d     = '0;
      rn_d     = '0;
      if (kind_q == KIND_ACQUIRE) begin
        if (!acq_ok) begin
          status_d = ST_POOL_EMPTY;
        end else begin
          if (depth_q != '0) begin
            depth_d = depth_m1;
          end else begin
            issued_d = issued_q + CntW'(1);
          end
          taken_d[pick]        = 1'b1;
          in_use_d[new_handle] = 1'b1;
          hres_we              = 1'b1;
          gh_d                 = new_handle;
          rn_d                 = pick;
        end
      end else begin
        if (!in_use_q[handle_q]) begin
          status_d = ST_BAD_HANDLE;
        end else begin
          taken_d[hres_rdata] = 1'b0;
          in_use_d[handle_q]  = 1'b0;
          if (depth_q < CntW'(SLOTS)) begin
            stack_we = 1'b1;
            depth_d  = depth_q + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q  <= '0;
      in_use_q <= '0;
      depth_q  <= '0;
      issued_q <= '0;
    end else begin
      taken_q  <= taken_d;
      in_use_q <= in_use_d;
      depth_q  <= depth_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      handle_q <= handle_i;
    end
    status_q <= status_d;
    gh_q     <= gh_d;
    rn_q     <= rn_d;
  end

  assign status_o          = status_q;
  assign granted_handle_o  = gh_q;
  assign resource_number_o = rn_q;

  // every handle in use owns exactly one taken resource
  a_bijection: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) == $countones(taken_q))
    else $error("handle and resource counts diverge");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CntW'(SLOTS) && issued_q <= CntW'(SLOTS))
    else $error("stack depth or issue count out of range");

  a_grant_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && kind_q == KIND_ACQUIRE && acq_ok
    |=> taken_q[$past(pick)] && in_use_q[$past(new_handle)])
    else $error("granted resource or handle not marked");

endmodule

@@ hdl/query_slot_allocator.sv @@
// query_slot_allocator: lowest-free resource pick with LIFO handle reuse.
// Sequence: S_IDLE accepts the request, S_EXEC commits behind the registered read of the
// handle map and freed-handle stack, then S_OUT holds the registered result until it is
// taken; no new request is accepted before then.
// Reset: all resources and handles free, stack empty, pool_size 64; the memories
// need no clearing pass and hold no valid bits.
module query_slot_allocator import qsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PoolW-1:0] cfg_wdata_i,
  qsa_req_if.sink          req_i,
  qsa_rsp_if.source        rsp_o
);

  cmd_t    cmd;
  status_e status;

  qsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  qsa_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .kind_i            (req_i.kind),
    .handle_i          (req_i.handle),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .status_o          (status),
    .granted_handle_o  (rsp_o.granted_handle),
    .resource_number_o (rsp_o.resource_number)
  );

  assign req_i.ready  = cmd.in_ready;
  assign rsp_o.valid  = cmd.out_valid;
  assign rsp_o.status = status;

endmodule
